### rtl/vcdp_pkg.sv
// Shared types and constants of the VCD value-change parser.
package vcdp_pkg;

    // Parser state
    typedef enum logic [2:0] {
        MODE_WS     = 3'd0,
        MODE_TIME   = 3'd1,
        MODE_VEC    = 3'd2,
        MODE_VEC_WS = 3'd3,
        MODE_ALIAS  = 3'd4,
        MODE_DOLLAR = 3'd5
    } parse_mode_t;

    // Result record kinds
    typedef enum logic [2:0] {
        KIND_TIME       = 3'd0,
        KIND_VEC_CHAR   = 3'd1,
        KIND_SCALAR     = 3'd2,
        KIND_ALIAS_CHAR = 3'd3,
        KIND_CHG_END    = 3'd4,
        KIND_STREAM_END = 3'd5
    } kind_t;

    // Most records that one byte can cause
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 3;

    // Characters the parser reacts to
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // All records caused by one byte; they share one character and one time,
    // except trailing records flagged to report time zero
    typedef struct packed {
        logic [63:0]                  stamp;
        logic [MAX_RESULTS-1:0]       zero_time;
        kind_t [MAX_RESULTS-1:0]      kinds;
        logic [COUNT_W-1:0]           count;
        logic [7:0]                   chr;
    } bundle_t;

endpackage

### rtl/vcd_value_change_parser.sv
// Top level of the VCD value-change parser: front end, bundle queue, result sequencer.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_byte_in, s_end_of_stream
//  m_       out        m_valid/m_ready    m_kind, m_character, m_timestamp, m_last_of_run
//
// One byte is accepted per cycle while the queue has room; a byte's records leave
// in order, the result port giving one record per cycle while m_ready is high. The queue
// holds FIFO_DEPTH bundles, so bytes keep flowing while the output stalls or a
// multi-record byte drains. Records pass the queue memory, then the back end's hold register.
// aresetn is synchronous, active low, and clears parse state, time and queue.
module vcd_value_change_parser import vcdp_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_character,
    output logic [63:0] m_timestamp,
    output logic        m_last_of_run
);

    logic    in_fire, push, pop, q_full, q_empty;
    bundle_t push_bundle, head_bundle;

    // Accept a byte whenever the queue has room
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    vcdp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .byte_in       (s_byte_in),
        .end_of_stream (s_end_of_stream),
        .push          (push),
        .bundle        (push_bundle)
    );

    vcdp_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_bundle),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .dout    (head_bundle)
    );

    vcdp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_dout        (head_bundle),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_character   (m_character),
        .m_timestamp   (m_timestamp),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### rtl/vcdp_front.sv
// Front end: classifies each accepted byte, tracks parse state and time, builds record bundles.
module vcdp_front import vcdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  byte_in,
    input  logic        end_of_stream,
    output logic        push,
    output bundle_t     bundle
);

    parse_mode_t mode_reg, mode_next, mode_mid, disp_mode;
    logic [63:0] acc_reg, acc_next, acc_mid;
    logic [63:0] cur_reg, cur_next, cur_mid;

    logic is_space, is_digit, is_hash, is_b, is_dollar, is_other;
    logic dispatching, time_end, zero_tail;
    logic [3:0]  digit;
    logic [63:0] acc_times_ten;
    logic [COUNT_W-1:0] n, step_n;
    kind_t [MAX_RESULTS-1:0] kinds;
    logic [MAX_RESULTS-1:0]  zero_time;

    // Classify the byte
    assign is_space  = (byte_in == CH_SPACE) || (byte_in == CH_TAB) ||
                       (byte_in == CH_CR) || (byte_in == CH_LF);
    assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign is_hash   = (byte_in == CH_HASH);
    assign is_b      = (byte_in == CH_B);
    assign is_dollar = (byte_in == CH_DOLLAR);
    assign is_other  = !(is_space || is_hash || is_b || is_dollar);
    assign digit     = byte_in[3:0];

    // Mode entered from whitespace skip
    always_comb begin
        if (is_hash) begin
            disp_mode = MODE_TIME;
        end else if (is_b) begin
            disp_mode = MODE_VEC;
        end else if (is_dollar) begin
            disp_mode = MODE_DOLLAR;
        end else if (is_space) begin
            disp_mode = MODE_WS;
        end else begin
            disp_mode = MODE_ALIAS;
        end
    end

    // Decode whether the byte starts a new item
    always_comb begin
        unique case (mode_reg)
            MODE_TIME:   dispatching = !is_digit;
            MODE_VEC, MODE_VEC_WS, MODE_ALIAS, MODE_DOLLAR: dispatching = 1'b0;
            default:     dispatching = 1'b1;
        endcase
    end

    assign time_end = (mode_reg == MODE_TIME) && !is_digit;

    // Next parse mode
    always_comb begin
        unique case (mode_reg)
            MODE_TIME:   mode_mid = is_digit ? MODE_TIME : disp_mode;
            MODE_VEC:    mode_mid = is_space ? MODE_VEC_WS : MODE_VEC;
            MODE_VEC_WS: mode_mid = is_space ? MODE_VEC_WS : MODE_ALIAS;
            MODE_ALIAS:  mode_mid = is_space ? MODE_WS : MODE_ALIAS;
            MODE_DOLLAR: mode_mid = (byte_in == CH_LF) ? MODE_WS : MODE_DOLLAR;
            default:     mode_mid = disp_mode;
        endcase
        mode_next = end_of_stream ? MODE_WS : mode_mid;
    end

    // Accumulate decimal time, wrapping modulo 2^64
    assign acc_times_ten = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};

    always_comb begin
        if ((mode_reg == MODE_TIME) && is_digit) begin
            acc_mid = acc_times_ten + {60'd0, digit};
        end else if (dispatching && is_hash) begin
            acc_mid = '0;
        end else begin
            acc_mid = acc_reg;
        end
        cur_mid  = time_end ? acc_reg : cur_reg;
        acc_next = end_of_stream ? '0 : acc_mid;
        cur_next = end_of_stream ? '0 : cur_mid;
    end

    // Collect the records this byte causes, in order
    always_comb begin
        n         = '0;
        zero_time = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            kinds[i] = KIND_TIME;
        end
        if (time_end) begin
            kinds[n[SLOT_W-1:0]] = KIND_TIME;
            n = n + 3'd1;
        end
        if (dispatching && is_other) begin
            kinds[n[SLOT_W-1:0]] = KIND_SCALAR;
            n = n + 3'd1;
        end
        case (mode_reg)
            MODE_VEC: begin
                if (!is_space) begin
                    kinds[n[SLOT_W-1:0]] = KIND_VEC_CHAR;
                    n = n + 3'd1;
                end
            end
            MODE_VEC_WS: begin
                if (!is_space) begin
                    kinds[n[SLOT_W-1:0]] = KIND_ALIAS_CHAR;
                    n = n + 3'd1;
                end
            end
            MODE_ALIAS: begin
                kinds[n[SLOT_W-1:0]] = is_space ? KIND_CHG_END : KIND_ALIAS_CHAR;
                n = n + 3'd1;
            end
            default: ;
        endcase
        step_n = n;
        // A '#' that ends one timestamp and opens an empty one at stream end
        zero_tail = end_of_stream && (mode_mid == MODE_TIME) && (step_n != 3'd0);
        if (end_of_stream) begin
            if (mode_mid == MODE_TIME) begin
                kinds[n[SLOT_W-1:0]]     = KIND_TIME;
                zero_time[n[SLOT_W-1:0]] = zero_tail;
                n = n + 3'd1;
            end else if ((mode_mid == MODE_VEC) || (mode_mid == MODE_VEC_WS) ||
                         (mode_mid == MODE_ALIAS)) begin
                kinds[n[SLOT_W-1:0]] = KIND_CHG_END;
                n = n + 3'd1;
            end
            kinds[n[SLOT_W-1:0]]     = KIND_STREAM_END;
            zero_time[n[SLOT_W-1:0]] = zero_tail;
            n = n + 3'd1;
        end
    end

    // Drive the bundle toward the queue
    always_comb begin
        bundle.stamp     = (end_of_stream && (mode_mid == MODE_TIME) && (step_n == 3'd0)) ?
                           acc_mid : cur_mid;
        bundle.zero_time = zero_time;
        bundle.kinds     = kinds;
        bundle.count     = n;
        bundle.chr       = byte_in;
        push             = in_fire && (n != 3'd0);
    end

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_WS;
            acc_reg  <= '0;
            cur_reg  <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cur_reg  <= cur_next;
        end
    end

endmodule

### rtl/vcdp_queue.sv
// Bundle queue between the front end and the result sequencer.
module vcdp_queue import vcdp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t din,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output bundle_t dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Store pushed bundles
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/vcdp_back.sv
// Back end: holds one bundle and hands out its records one transaction at a time.
module vcdp_back import vcdp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  bundle_t     q_dout,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_character,
    output logic [63:0] m_timestamp,
    output logic        m_last_of_run
);

    bundle_t             hold_reg;
    logic                valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                is_last, advance;
    kind_t               cur_kind;

    assign cur_kind = hold_reg.kinds[slot_reg];
    assign is_last  = ({1'b0, slot_reg} == (hold_reg.count - 3'd1));
    assign advance  = !valid_reg || (m_ready && is_last);
    assign q_pop    = advance && !q_empty;

    // Load the next bundle or step to the next record
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end else if (advance) begin
            valid_reg <= !q_empty;
            slot_reg  <= '0;
        end else if (m_ready) begin
            slot_reg  <= slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            hold_reg <= q_dout;
        end
    end

    // Present the current record
    always_comb begin
        m_valid       = valid_reg;
        m_kind        = cur_kind;
        m_timestamp   = hold_reg.zero_time[slot_reg] ? 64'd0 : hold_reg.stamp;
        m_last_of_run = is_last;
        case (cur_kind) inside
            KIND_VEC_CHAR, KIND_SCALAR, KIND_ALIAS_CHAR: m_character = hold_reg.chr;
            default:                                     m_character = 8'd0;
        endcase
    end

endmodule

### rtl/vcdp_checker.sv
// Port-level checks for the VCD value-change parser, bound to the top level.
module vcdp_checker import vcdp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_byte_in,
    input logic        s_end_of_stream,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [7:0]  m_character,
    input logic [63:0] m_timestamp,
    input logic        m_last_of_run
);

    // Hold a stalled result transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_character)
            && $stable(m_timestamp) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // Records without a character carry zero
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_TIME || m_kind == KIND_CHG_END ||
                    m_kind == KIND_STREAM_END) |-> m_character == 8'd0)
        else $error("nonzero character on a record without one");

    // Stream end closes its byte's run
    a_stream_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_STREAM_END |-> m_last_of_run)
        else $error("stream end not last of run");

    // A change end that is not last is followed at once by the stream end
    a_chg_end_then_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_CHG_END && !m_last_of_run
            |=> m_valid && m_kind == KIND_STREAM_END)
        else $error("change end inside a run not followed by stream end");

endmodule

bind vcd_value_change_parser vcdp_checker u_checker (.*);
